/* sv/dpd_pkg.sv */
// Shared types and constants for the depth pixel deprojection block.
// No dependencies.
`timescale 1ns / 1ps
package dpd_pkg;
    localparam int MaxDim   = 4096;
    localparam int FracBits = 8;
    localparam int CntW     = $clog2(MaxDim);
    localparam int DimW     = 13;
    localparam int CenW     = 20;
    localparam int FocW     = 21;
    localparam int DepW     = 16;
    localparam int MagW     = CntW + FracBits + 1;
    localparam int NumW     = MagW + DepW + FracBits;
    localparam int QW       = NumW;
    localparam int CfgIdxW  = 3;
    localparam int CfgDatW  = 21;

    typedef enum logic [CfgIdxW-1:0] {
        t_reg_width  = 3'd0,
        t_reg_height = 3'd1,
        t_reg_cen_x  = 3'd2,
        t_reg_cen_y  = 3'd3,
        t_reg_foc_x  = 3'd4,
        t_reg_foc_y  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        t_st_idle = 2'd0,
        t_st_mul  = 2'd1,
        t_st_div  = 2'd2,
        t_st_out  = 2'd3
    } t_state;

    typedef struct packed {
        logic            valid;
        logic [DepW-1:0] depth;
        logic            last;
        logic [MagW-1:0] mag_x;
        logic            neg_x;
        logic [MagW-1:0] mag_y;
        logic            neg_y;
    } t_job;

    typedef struct packed {
        logic            point_valid;
        logic [31:0]     x_q8;
        logic [31:0]     y_q8;
        logic [DepW-1:0] z_mm;
        logic            frame_last;
    } t_point;
endpackage

/* sv/dpd_in_if.sv */
// Input channel: depth samples. Depends on dpd_pkg.
`timescale 1ns / 1ps
interface dpd_in_if;
    logic                       valid;
    logic                       ready;
    logic [dpd_pkg::DepW-1:0]   depth_mm;
    modport source (output valid, output depth_mm, input ready);
    modport sink   (input valid, input depth_mm, output ready);
endinterface

/* sv/dpd_out_if.sv */
// Output channel: 3-D points. Depends on dpd_pkg.
`timescale 1ns / 1ps
interface dpd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       point_valid;
    logic signed [31:0]         x_q8;
    logic signed [31:0]         y_q8;
    logic [dpd_pkg::DepW-1:0]   z_mm;
    logic                       frame_last;
    modport source (output valid, output point_valid, output x_q8, output y_q8,
                    output z_mm, output frame_last, input ready);
    modport sink   (input valid, input point_valid, input x_q8, input y_q8,
                    input z_mm, input frame_last, output ready);
endinterface

/* sv/dpd_front.sv */
// Front end: raster counters and centered magnitudes per sample.
// Depends on dpd_pkg.
`timescale 1ns / 1ps
module dpd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dpd_pkg::DepW-1:0]    i_depth,
    input  logic [dpd_pkg::DimW-1:0]    i_width,
    input  logic [dpd_pkg::DimW-1:0]    i_height,
    input  logic [dpd_pkg::CenW-1:0]    i_cen_x,
    input  logic [dpd_pkg::CenW-1:0]    i_cen_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dpd_pkg::t_job               o_job
);
    logic [dpd_pkg::CntW-1:0] r_col, n_col, r_row, n_row;
    logic [dpd_pkg::DimW-1:0] w_lim, h_lim;
    logic col_end, row_end, take;
    logic [dpd_pkg::MagW-1:0] px, py, cx, cy;

    always_comb begin
        w_lim = (i_width == '0) ? dpd_pkg::DimW'(1) :
                (i_width > dpd_pkg::DimW'(dpd_pkg::MaxDim)) ?
                dpd_pkg::DimW'(dpd_pkg::MaxDim) : i_width;
        h_lim = (i_height == '0) ? dpd_pkg::DimW'(1) :
                (i_height > dpd_pkg::DimW'(dpd_pkg::MaxDim)) ?
                dpd_pkg::DimW'(dpd_pkg::MaxDim) : i_height;
        col_end = {1'b0, r_col} >= w_lim - dpd_pkg::DimW'(1);
        row_end = {1'b0, r_row} >= h_lim - dpd_pkg::DimW'(1);
        take = i_valid && o_ready;
        n_col = r_col;
        n_row = r_row;
        if (take) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        px = {1'b0, r_col, {dpd_pkg::FracBits{1'b0}}};
        py = {1'b0, r_row, {dpd_pkg::FracBits{1'b0}}};
        cx = dpd_pkg::MagW'(i_cen_x);
        cy = dpd_pkg::MagW'(i_cen_y);
    end

    assign o_ready = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (o_ready) o_valid <= i_valid;
        end
        if (take) begin
            o_job.valid <= i_depth != '0;
            o_job.depth <= i_depth;
            o_job.last  <= col_end && row_end;
            o_job.neg_x <= px < cx;
            o_job.mag_x <= (px < cx) ? cx - px : px - cx;
            o_job.neg_y <= py < cy;
            o_job.mag_y <= (py < cy) ? cy - py : py - cy;
        end
    end
endmodule

/* sv/dpd_fifo.sv */
// Two-entry queue between front and back end. Depends on dpd_pkg.
`timescale 1ns / 1ps
module dpd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dpd_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output dpd_pkg::t_job  o_job
);
    dpd_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_job;
    end
endmodule

/* sv/dpd_back.sv */
// Back end: multiply, restoring divide for x and y in parallel, saturate.
// Depends on dpd_pkg.
`timescale 1ns / 1ps
module dpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  dpd_pkg::t_job               i_job,
    input  logic [dpd_pkg::FocW-1:0]    i_foc_x,
    input  logic [dpd_pkg::FocW-1:0]    i_foc_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dpd_pkg::t_point             o_pt
);
    localparam int NW = dpd_pkg::NumW;
    localparam int SW = $clog2(NW);
    localparam int PW = dpd_pkg::MagW + dpd_pkg::DepW;

    dpd_pkg::t_state r_st, n_st;
    dpd_pkg::t_job   r_job;
    logic [NW-1:0]   r_nx, r_ny, r_qx, r_qy;
    logic [dpd_pkg::FocW:0] r_rx, r_ry, tx, ty;
    logic [SW-1:0]   r_cnt;
    logic            load, mul, step, emit;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            dpd_pkg::t_st_idle: if (i_valid) n_st = dpd_pkg::t_st_mul;
            dpd_pkg::t_st_mul:  n_st = dpd_pkg::t_st_div;
            dpd_pkg::t_st_div:  if (r_cnt == SW'(NW - 1)) n_st = dpd_pkg::t_st_out;
            dpd_pkg::t_st_out:  if (!o_valid || i_ready) n_st = dpd_pkg::t_st_idle;
            default:            n_st = dpd_pkg::t_st_idle;
        endcase
    end

    always_comb begin
        load = r_st == dpd_pkg::t_st_idle && i_valid;
        mul  = r_st == dpd_pkg::t_st_mul;
        step = r_st == dpd_pkg::t_st_div;
        emit = r_st == dpd_pkg::t_st_out && (!o_valid || i_ready);
        o_ready = r_st == dpd_pkg::t_st_idle;
        tx = {r_rx[dpd_pkg::FocW-1:0], r_nx[NW-1]};
        ty = {r_ry[dpd_pkg::FocW-1:0], r_ny[NW-1]};
    end

    function automatic logic [31:0] sat(input logic [NW-1:0] q, input logic neg,
                                        input logic [NW-1:0] num,
                                        input logic [dpd_pkg::FocW-1:0] f);
        logic [NW-1:0] m;
        begin
            m = (f == '0) ? '1 : q;
            if (num == '0) sat = '0;
            else if (neg) sat = (m > NW'(33'h80000000)) ? 32'h80000000 : 32'(-m);
            else sat = (m > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : m[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= dpd_pkg::t_st_idle;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
        if (load) r_job <= i_job;
        if (mul) begin
            r_nx  <= NW'({PW'(r_job.mag_x) * PW'(r_job.depth),
                          {dpd_pkg::FracBits{1'b0}}});
            r_ny  <= NW'({PW'(r_job.mag_y) * PW'(r_job.depth),
                          {dpd_pkg::FracBits{1'b0}}});
            r_rx  <= '0;
            r_ry  <= '0;
            r_cnt <= '0;
        end
        if (step) begin
            // shift one numerator bit in, subtract divisor where it fits
            r_nx <= {r_nx[NW-2:0], 1'b0};
            r_ny <= {r_ny[NW-2:0], 1'b0};
            if (tx >= {1'b0, i_foc_x}) begin
                r_rx <= tx - {1'b0, i_foc_x};
                r_qx <= {r_qx[NW-2:0], 1'b1};
            end else begin
                r_rx <= tx;
                r_qx <= {r_qx[NW-2:0], 1'b0};
            end
            if (ty >= {1'b0, i_foc_y}) begin
                r_ry <= ty - {1'b0, i_foc_y};
                r_qy <= {r_qy[NW-2:0], 1'b1};
            end else begin
                r_ry <= ty;
                r_qy <= {r_qy[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (mul) begin
            r_qx <= '0;
            r_qy <= '0;
        end
        if (emit) begin
            o_pt.point_valid <= r_job.valid;
            o_pt.z_mm        <= r_job.valid ? r_job.depth : '0;
            o_pt.frame_last  <= r_job.last;
            // numerator is zero exactly when magnitude or depth is
            o_pt.x_q8 <= r_job.valid ? sat(r_qx, r_job.neg_x,
                         NW'(r_job.mag_x), i_foc_x) : '0;
            o_pt.y_q8 <= r_job.valid ? sat(r_qy, r_job.neg_y,
                         NW'(r_job.mag_y), i_foc_y) : '0;
        end
    end
endmodule

/* sv/depth_pixel_deprojection.sv */
// Top level of the depth pixel deprojection block.
// Depends on dpd_pkg, dpd_in_if, dpd_out_if, dpd_front, dpd_fifo, dpd_back.
`timescale 1ns / 1ps
// Usage:
//   in  : depth_mm samples in raster order, valid/ready transfer.
//   out : one point per sample (point_valid, x_q8, y_q8, z_mm, frame_last).
//   cfg : i_cfg_we/i_cfg_idx/i_cfg_data; write only while idle.
// Each sample passes through the back end in order: a load step, a multiply
// step, bit-serial restoring division (x and y dividers run side by side,
// one quotient bit per cycle), then a step to saturate and register.
// The back end takes no new sample until the last one has been output.
// The front end and a two-entry queue absorb the next samples meanwhile.
// Reset clears the column/row counters, loads the register defaults
// (640x480, center 320,240, focal 600) and empties the queue.
// When the receiver stalls the result is held in the output register and
// the divider waits; the queue then fills and input ready drops.
module depth_pixel_deprojection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dpd_in_if.sink                      in_ch,
    dpd_out_if.source                   out_ch,
    input  logic                        i_cfg_we,
    input  logic [dpd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [dpd_pkg::CfgDatW-1:0] i_cfg_data
);
    logic [dpd_pkg::DimW-1:0] r_width, r_height;
    logic [dpd_pkg::CenW-1:0] r_cen_x, r_cen_y;
    logic [dpd_pkg::FocW-1:0] r_foc_x, r_foc_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dpd_pkg::DimW'(640);
            r_height <= dpd_pkg::DimW'(480);
            r_cen_x  <= dpd_pkg::CenW'(81920);
            r_cen_y  <= dpd_pkg::CenW'(61440);
            r_foc_x  <= dpd_pkg::FocW'(153600);
            r_foc_y  <= dpd_pkg::FocW'(153600);
        end else if (i_cfg_we) begin
            unique case (dpd_pkg::t_reg_idx'(i_cfg_idx))
                dpd_pkg::t_reg_width:  r_width  <= i_cfg_data[dpd_pkg::DimW-1:0];
                dpd_pkg::t_reg_height: r_height <= i_cfg_data[dpd_pkg::DimW-1:0];
                dpd_pkg::t_reg_cen_x:  r_cen_x  <= i_cfg_data[dpd_pkg::CenW-1:0];
                dpd_pkg::t_reg_cen_y:  r_cen_y  <= i_cfg_data[dpd_pkg::CenW-1:0];
                dpd_pkg::t_reg_foc_x:  r_foc_x  <= i_cfg_data;
                dpd_pkg::t_reg_foc_y:  r_foc_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    dpd_pkg::t_job f_job, q_job;
    dpd_pkg::t_point pt;

    dpd_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_depth(in_ch.depth_mm),
        .i_width(r_width), .i_height(r_height), .i_cen_x(r_cen_x), .i_cen_y(r_cen_y),
        .o_valid(f_valid), .i_ready(f_ready), .o_job(f_job)
    );

    dpd_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    dpd_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .i_foc_x(r_foc_x), .i_foc_y(r_foc_y),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_pt(pt)
    );

    assign out_ch.point_valid = pt.point_valid;
    assign out_ch.x_q8        = pt.x_q8;
    assign out_ch.y_q8        = pt.y_q8;
    assign out_ch.z_mm        = pt.z_mm;
    assign out_ch.frame_last  = pt.frame_last;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.point_valid |->
        out_ch.x_q8 == 0 && out_ch.y_q8 == 0 && out_ch.z_mm == 0)
        else $error("invalid point carries nonzero coordinates");
    a_valid_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.point_valid |-> out_ch.z_mm != 0)
        else $error("valid point with zero depth");
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_ready |=> !q_ready)
        else $error("back end took two jobs in a row");
endmodule
